### sv/serial_rx_line_edit_buffer_macros.svh
// Assertion helpers for the checker file.
`ifndef SERIAL_RX_LINE_EDIT_BUFFER_MACROS_SVH
`define SERIAL_RX_LINE_EDIT_BUFFER_MACROS_SVH

// Checked outside reset only.
`define SRLEB_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define SRLEB_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/srleb_pkg.sv
`timescale 1ns / 1ps

package srleb_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int FILL_W = 6;

    localparam int DEF_BUF_DEPTH = 32;
    localparam int DEF_LINE_MAX  = 32;

    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

    typedef enum logic [OP_W-1:0] {
        OP_RX_BYTE   = 2'd0,
        OP_READ_BYTE = 2'd1,
        OP_READ_LINE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_POP,
        S_EMIT
    } t_state;

endpackage

### sv/srleb_if.sv
`timescale 1ns / 1ps

// Command channel.
interface srleb_in_if import srleb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, opcode, rx_byte, input ready);
    modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

// Result channel.
interface srleb_out_if import srleb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              out_last;
    logic              dropped;
    logic              line_ready;
    logic              not_empty;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, out_byte, out_valid, out_last, dropped, line_ready,
                    not_empty, fill_count, input ready);
    modport sink   (input valid, out_byte, out_valid, out_last, dropped, line_ready,
                    not_empty, fill_count, output ready);
endinterface

### sv/serial_rx_line_edit_buffer.sv
`timescale 1ns / 1ps

// Receive line buffer with backspace editing. Each command beat is one of:
// received byte (CR stored as LF; DEL removes the newest byte when the buffer
// is not empty; a byte arriving at a full buffer is lost and flagged),
// read one byte (pops the oldest; empty gives one beat with out_valid low),
// or read line (emits up to LINE_MAX oldest bytes, out_last on the final one,
// then the whole buffer is emptied). Opcode 3 returns one status beat.
// Every result beat carries line_ready, not_empty and fill_count as they
// stand after that beat. Bytes live in a BUF_DEPTH-entry store with a
// registered read port; one command is worked on at a time. Steps: a
// received byte is accepted, then emitted; a DEL with data or a read byte is
// accepted, read from the store, then emitted; a read line is accepted, then
// each emitted byte needs a store read followed by the output register
// load. Each emit waits while the result side holds off ready. The command
// side is ready again as soon as the final result sits in the output register.
// The store needs no clearing pass; only written entries are ever used.
module serial_rx_line_edit_buffer import srleb_pkg::*; #(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH,
    parameter int LINE_MAX  = DEF_LINE_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srleb_in_if.sink    i_in,
    srleb_out_if.source o_out
);

    localparam int IDX_W  = $clog2(BUF_DEPTH);
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LCNT_W = $clog2(LINE_MAX + 1);

    // byte store, one write and one read port, read data registered
    logic [BYTE_W-1:0] mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // control state
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [CNT_W-1:0]  r_nl, n_nl;
    logic [LCNT_W-1:0] r_left, n_left;
    logic              r_line, n_line;

    // pending result, waits for the output register
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_ev, n_ev;
    logic              r_el, n_el;
    logic              r_drop, n_drop;

    // output register
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_valid, r_o_last, r_o_drop, r_o_lr, r_o_ba;
    logic [FILL_W-1:0] r_o_fill;

    logic              in_acc;
    logic              out_load;
    logic [BYTE_W-1:0] ch;
    logic [SUM_W-1:0]  tail_sum, newest_sum;
    logic [IDX_W-1:0]  tail_pos, newest_pos, oldest_inc;
    logic              is_full, is_empty;

    // ring positions: sums stay below twice the depth, one subtract wraps them
    always_comb begin
        tail_sum   = SUM_W'(r_oldest) + SUM_W'(r_held);
        newest_sum = tail_sum - SUM_W'(1);
        tail_pos   = (tail_sum >= SUM_W'(BUF_DEPTH))
                   ? IDX_W'(tail_sum - SUM_W'(BUF_DEPTH)) : IDX_W'(tail_sum);
        newest_pos = (newest_sum >= SUM_W'(BUF_DEPTH))
                   ? IDX_W'(newest_sum - SUM_W'(BUF_DEPTH)) : IDX_W'(newest_sum);
        oldest_inc = (r_oldest == IDX_W'(BUF_DEPTH - 1)) ? '0 : r_oldest + IDX_W'(1);
        is_full    = (r_held >= CNT_W'(BUF_DEPTH));
        is_empty   = (r_held == '0);
        ch         = (i_in.rx_byte == CH_CR) ? CH_LF : i_in.rx_byte;
    end

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_held   <= '0;
            r_nl     <= '0;
            r_left   <= '0;
            r_line   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_held   <= n_held;
            r_nl     <= n_nl;
            r_left   <= n_left;
            r_line   <= n_line;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_ev   <= n_ev;
        r_el   <= n_el;
        r_drop <= n_drop;
        if (out_load) begin
            r_o_byte  <= r_ev ? r_byte : '0;
            r_o_valid <= r_ev;
            r_o_last  <= r_el;
            r_o_drop  <= r_drop;
            r_o_lr    <= is_full || (r_nl != '0);
            r_o_ba    <= !is_empty;
            r_o_fill  <= FILL_W'(r_held);   // wraps at a depth of 64
        end
    end

    // sequencer: next state, store access, counter updates
    always_comb begin
        n_state   = r_state;
        n_oldest  = r_oldest;
        n_held    = r_held;
        n_nl      = r_nl;
        n_left    = r_left;
        n_line    = r_line;
        n_byte    = r_byte;
        n_ev      = r_ev;
        n_el      = r_el;
        n_drop    = r_drop;
        n_ov      = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_ov);
        mem_we    = 1'b0;
        mem_waddr = tail_pos;
        mem_wdata = ch;
        mem_raddr = r_oldest;

        case (r_state)
            S_IDLE: begin
                n_ev   = 1'b0;
                n_el   = 1'b1;
                n_drop = 1'b0;
                n_line = 1'b0;
                if (t_opcode'(i_in.opcode) == OP_RX_BYTE) begin
                    mem_raddr = newest_pos;
                end
                if (in_acc) begin
                    case (t_opcode'(i_in.opcode))
                        OP_RX_BYTE: begin
                            if (ch == CH_DEL && !is_empty) begin
                                n_state = S_DEL;        // need the newest byte first
                            end else if (!is_full) begin
                                mem_we  = 1'b1;
                                n_held  = r_held + CNT_W'(1);
                                if (ch == CH_LF) begin
                                    n_nl = r_nl + CNT_W'(1);
                                end
                                n_state = S_EMIT;
                            end else begin
                                n_drop  = 1'b1;
                                n_state = S_EMIT;
                            end
                        end
                        OP_READ_BYTE: begin
                            n_state = is_empty ? S_EMIT : S_POP;
                        end
                        OP_READ_LINE: begin
                            n_line  = 1'b1;
                            n_left  = (int'(r_held) > LINE_MAX)
                                    ? LCNT_W'(LINE_MAX) : LCNT_W'(r_held);
                            n_state = is_empty ? S_EMIT : S_POP;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_DEL: begin
                if (r_rdata == CH_LF && r_nl != '0) begin
                    n_nl = r_nl - CNT_W'(1);
                end
                n_held  = r_held - CNT_W'(1);
                n_state = S_EMIT;
            end
            S_POP: begin
                n_byte   = r_rdata;
                n_ev     = 1'b1;
                n_el     = !r_line || (r_left == LCNT_W'(1));
                n_left   = r_left - LCNT_W'(1);
                n_oldest = oldest_inc;
                n_held   = r_held - CNT_W'(1);
                if (r_rdata == CH_LF && r_nl != '0) begin
                    n_nl = r_nl - CNT_W'(1);
                end
                if (r_line && r_left == LCNT_W'(1)) begin
                    // end of line read: the rest is discarded
                    n_oldest = '0;
                    n_held   = '0;
                    n_nl     = '0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    // mem_raddr already points at the oldest byte
                    n_state = r_el ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.out_valid  = r_o_valid;
    assign o_out.out_last   = r_o_last;
    assign o_out.dropped    = r_o_drop;
    assign o_out.line_ready = r_o_lr;
    assign o_out.not_empty  = r_o_ba;
    assign o_out.fill_count = r_o_fill;

endmodule

### sv/srleb_checker.sv
`timescale 1ns / 1ps
`include "serial_rx_line_edit_buffer_macros.svh"

module srleb_checker import srleb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_out_valid,
    input logic              i_out_last,
    input logic              i_dropped,
    input logic              i_line_ready,
    input logic              i_not_empty,
    input logic [FILL_W-1:0] i_fill_count
);

    logic drop_ok;
    logic empty_ok;
    logic busy_ok;

    assign drop_ok  = i_line_ready && i_not_empty && i_out_last && !i_out_out_valid;
    assign empty_ok = !i_line_ready && (i_fill_count == '0);
    assign busy_ok  = i_out_out_valid && !i_in_ready;

    // no result beat right after reset
    `SRLEB_CHECK_ALWAYS(a_rst_quiet, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // a stalled result stays up
    `SRLEB_CHECK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result beat withdrawn")

    // a lost byte means a full buffer and a lone status beat
    `SRLEB_CHECK(a_drop_full, i_out_valid && i_dropped |-> drop_ok, "drop without full buffer")

    // an empty buffer reports no line and no fill
    `SRLEB_CHECK(a_empty_status, i_out_valid && !i_not_empty |-> empty_ok, "empty status mismatch")

    // mid-line beats carry data and block new commands
    `SRLEB_CHECK(a_line_busy, i_out_valid && !i_out_last |-> busy_ok, "line run not exclusive")

endmodule

bind serial_rx_line_edit_buffer srleb_checker u_srleb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_out_valid (o_out.out_valid),
    .i_out_last      (o_out.out_last),
    .i_dropped       (o_out.dropped),
    .i_line_ready    (o_out.line_ready),
    .i_not_empty     (o_out.not_empty),
    .i_fill_count    (o_out.fill_count)
);

### tb/srleb_line_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the line buffer and checks
// every result beat against the oldest outstanding prediction.
module srleb_line_checker import srleb_pkg::*; #(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH,
    parameter int LINE_MAX  = DEF_LINE_MAX
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srleb_in_if  i_cmd,
    srleb_out_if i_res,
    output int   o_fail_count,
    output int   o_beats_owed
);

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic              drop;
        logic              line_rdy;
        logic              avail;
        logic [FILL_W-1:0] fill;
    } t_line_beat;

    t_line_beat        owed_beats[$];
    logic [BYTE_W-1:0] shadow_store [BUF_DEPTH];
    int                head;
    int                held;
    int                lf_held;

    function automatic int wrap(input int p);
        return p % BUF_DEPTH;
    endfunction

    // Status fields reflect the shadow buffer as it stands right now.
    task automatic push_beat(input logic [BYTE_W-1:0] data, input logic valid,
                             input logic last, input logic drop);
        t_line_beat b;
        b.data     = data;
        b.valid    = valid;
        b.last     = last;
        b.drop     = drop;
        b.line_rdy = (held >= BUF_DEPTH) || (lf_held > 0);
        b.avail    = held > 0;
        b.fill     = held[FILL_W-1:0];
        owed_beats.push_back(b);
    endtask

    task automatic pop_head(output logic [BYTE_W-1:0] b);
        b    = shadow_store[head];
        head = wrap(head + 1);
        held--;
        if (b == CH_LF && lf_held > 0)
            lf_held--;
    endtask

    task automatic predict_edit(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] b;
        logic              drop;
        int                n;
        int                pos;
        case (op)
            OP_RX_BYTE: begin
                c    = (ch == CH_CR) ? CH_LF : ch;
                drop = 1'b0;
                if (c == CH_DEL && held > 0) begin
                    pos = wrap(head + held - 1);
                    if (shadow_store[pos] == CH_LF && lf_held > 0)
                        lf_held--;
                    held--;
                end else if (held < BUF_DEPTH) begin
                    shadow_store[wrap(head + held)] = c;
                    held++;
                    if (c == CH_LF)
                        lf_held++;
                end else begin
                    drop = 1'b1;
                end
                push_beat('0, 1'b0, 1'b1, drop);
            end
            OP_READ_BYTE: begin
                if (held == 0) begin
                    push_beat('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    pop_head(b);
                    push_beat(b, 1'b1, 1'b1, 1'b0);
                end
            end
            OP_READ_LINE: begin
                if (held == 0) begin
                    push_beat('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    n = (held > LINE_MAX) ? LINE_MAX : held;
                    for (int k = 0; k < n; k++) begin
                        pop_head(b);
                        // final beat of a line read discards whatever is left
                        if (k == n - 1) begin
                            held    = 0;
                            lf_held = 0;
                            head    = 0;
                        end
                        push_beat(b, 1'b1, k == n - 1, 1'b0);
                    end
                end
            end
            default: push_beat('0, 1'b0, 1'b1, 1'b0);
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t srleb check: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_line_beat want;
        if (!i_rst_n) begin
            head         = 0;
            held         = 0;
            lf_held      = 0;
            o_fail_count = 0;
            owed_beats.delete();
            foreach (shadow_store[i])
                shadow_store[i] = '0;
        end else begin
            // output side first: a beat never belongs to a command taken on the same edge
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (owed_beats.size() == 0) begin
                    note_mismatch("result beat with nothing owed, out_byte",
                                  int'(i_res.out_byte), 0);
                end else begin
                    want = owed_beats.pop_front();
                    if (i_res.out_byte !== want.data)
                        note_mismatch("out_byte", int'(i_res.out_byte), int'(want.data));
                    if (i_res.out_valid !== want.valid)
                        note_mismatch("out_valid", int'(i_res.out_valid), int'(want.valid));
                    if (i_res.out_last !== want.last)
                        note_mismatch("out_last", int'(i_res.out_last), int'(want.last));
                    if (i_res.dropped !== want.drop)
                        note_mismatch("dropped", int'(i_res.dropped), int'(want.drop));
                    if (i_res.line_ready !== want.line_rdy)
                        note_mismatch("line_ready", int'(i_res.line_ready),
                                      int'(want.line_rdy));
                    if (i_res.not_empty !== want.avail)
                        note_mismatch("not_empty", int'(i_res.not_empty), int'(want.avail));
                    if (i_res.fill_count !== want.fill)
                        note_mismatch("fill_count", int'(i_res.fill_count), int'(want.fill));
                end
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1)
                predict_edit(i_cmd.opcode, i_cmd.rx_byte);
        end
        o_beats_owed <= owed_beats.size();
    end

endmodule

### tb/tb_serial_rx_line_edit_buffer.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the receive line buffer. Checking lives in
// srleb_line_checker, which sits beside the DUT on the same channels.
module tb_serial_rx_line_edit_buffer;
    import srleb_pkg::*;

    // opcode 3 has no enum member; the block answers with a status beat
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RUN_ITEMS       = 210;   // total command beats, directed included
    localparam int HOLD_OFF_CYCLES = 300;   // long result-side stall
    localparam int SETTLE_CYCLES   = 16;    // drain margin after last beat

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int sent_beats;
    bit calm_in;    // no command gaps while set
    bit calm_out;   // result side draws no random stalls while set
    int fail_count;
    int beats_owed;

    srleb_in_if  cmd_ch ();
    srleb_out_if res_ch ();

    serial_rx_line_edit_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    srleb_line_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_beats_owed (beats_owed)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Characters a terminal would plausibly send, with edits and line ends
    // mixed in, plus a share of arbitrary bytes.
    function automatic logic [BYTE_W-1:0] draw_typed_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return BYTE_W'($urandom_range(32, 126));
        if (r < 70)
            return CH_DEL;
        if (r < 78)
            return CH_CR;
        if (r < 83)
            return CH_LF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // One command beat. valid is only lowered when a gap follows, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] ch);
        int gap;
        gap = calm_in ? 0 : draw_gap();
        if (gap > 0) begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.opcode  <= OP_W'($urandom_range(0, 3));
            cmd_ch.rx_byte <= BYTE_W'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= op;
        cmd_ch.rx_byte <= ch;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        sent_beats++;
    endtask

    // Result side: random stalls, calm stretches, and a couple of long
    // hold-offs so the buffer backs up into the command channel.
    initial begin
        int hold;
        int stall;
        int cyc;
        res_ch.ready <= 1'b0;
        hold     = 0;
        stall    = 0;
        cyc      = 0;
        calm_out = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (cyc == 400 || cyc == 5000)
                hold = HOLD_OFF_CYCLES;
            if (cyc % 300 == 0)
                calm_out = ($urandom_range(0, 5) == 0);
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                if (!calm_out && $urandom_range(0, 2) == 0)
                    stall = draw_gap();
            end
            @(posedge i_clk);
            cyc++;
        end
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("tb_serial_rx_line_edit_buffer: FAIL");
        $finish;
    end

    initial begin
        int r;
        int len;
        int target;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.opcode  <= OP_RX_BYTE;
        cmd_ch.rx_byte <= '0;
        sent_beats = 0;
        calm_in    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        send_cmd(OP_READ_BYTE, 8'h00);  // read byte on empty buffer
        send_cmd(OP_READ_LINE, 8'h00);  // read line on empty buffer
        send_cmd(OP_UNUSED, 8'hA5);     // unused opcode: status only
        send_cmd(OP_RX_BYTE, CH_DEL);   // DEL into empty buffer gets stored
        send_cmd(OP_RX_BYTE, 8'h00);
        send_cmd(OP_RX_BYTE, 8'hFF);
        send_cmd(OP_RX_BYTE, CH_CR);    // CR lands as LF, line_ready rises
        send_cmd(OP_RX_BYTE, CH_DEL);   // backspace over the LF, line_ready falls
        send_cmd(OP_RX_BYTE, CH_LF);
        send_cmd(OP_READ_BYTE, 8'hFF);  // pops the stored DEL
        send_cmd(OP_READ_LINE, 8'hFF);  // 00, FF, LF then empty
        send_cmd(OP_RX_BYTE, 8'h41);
        send_cmd(OP_RX_BYTE, CH_DEL);   // removes 'A'
        send_cmd(OP_RX_BYTE, CH_DEL);   // buffer empty again: stored
        send_cmd(OP_READ_BYTE, 8'h5A);
        send_cmd(OP_READ_BYTE, 8'h00);  // empty again

        // ---- random ----
        // Mostly typed lines followed by a read; long lines push the buffer
        // to full so drops and full-buffer line_ready show up.
        target = RUN_ITEMS;
        while (sent_beats < target) begin
            calm_in = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                  : $urandom_range(1, 12);
                repeat (len) send_cmd(OP_RX_BYTE, draw_typed_char());
                if ($urandom_range(0, 2) != 0)
                    send_cmd(OP_RX_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
                if ($urandom_range(0, 4) < 3)
                    send_cmd(OP_READ_LINE, BYTE_W'($urandom_range(0, 255)));
                else
                    repeat ($urandom_range(1, 5))
                        send_cmd(OP_READ_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else if (r < 72) begin
                repeat ($urandom_range(1, 4))
                    send_cmd(OP_READ_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else if (r < 84) begin
                send_cmd(OP_READ_LINE, BYTE_W'($urandom_range(0, 255)));
            end else begin
                // noise: any opcode, any byte
                repeat ($urandom_range(1, 3))
                    send_cmd(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
            end
        end
        cmd_ch.valid <= 1'b0;

        // drain: owed count is registered, so look at it after the next edge
        @(posedge i_clk);
        while (beats_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && beats_owed == 0)
            $display("tb_serial_rx_line_edit_buffer: PASS");
        else
            $display("tb_serial_rx_line_edit_buffer: FAIL");
        $finish;
    end

endmodule

### serial_rx_line_edit_buffer.f
+incdir+sv
sv/srleb_pkg.sv
sv/srleb_if.sv
sv/serial_rx_line_edit_buffer.sv
sv/srleb_checker.sv
tb/srleb_line_checker.sv
tb/tb_serial_rx_line_edit_buffer.sv
